// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define RBM_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("rbm assertion failed");

// consequence holds in the same cycle as the antecedent
`define RBM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbm assertion failed");

// consequence holds in the cycle after the antecedent
`define RBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbm assertion failed");

`endif

// ----- rtl/rbm_pkg.sv -----
// types, register indexes and constants of the radial band mask
package rbm_pkg;

    typedef logic [7:0]  cfg_idx_t;
    typedef logic [10:0] dim_t;
    typedef logic [15:0] gain_t;

    localparam cfg_idx_t REG_WIDTH  = 8'd0;
    localparam cfg_idx_t REG_HEIGHT = 8'd1;
    localparam cfg_idx_t REG_INNER  = 8'd2;
    localparam cfg_idx_t REG_OUTER  = 8'd3;

    localparam dim_t WIDTH_RST  = 11'd256;
    localparam dim_t HEIGHT_RST = 11'd256;
    localparam dim_t INNER_RST  = 11'd64;
    localparam dim_t OUTER_RST  = 11'd128;

    typedef enum logic [1:0] {
        BAND_TRANS,
        BAND_INSIDE,
        BAND_OUTSIDE
    } band_t;

    typedef struct packed {
        logic  op;
        band_t band;
        logic  swap;
    } ctl_t;

    localparam int GAIN_FRAC_BITS = 15;
    localparam int GAIN_SH        = 30 - GAIN_FRAC_BITS;
    localparam logic [31:0] GAIN_RND = 32'd1 << (GAIN_SH - 1);
    localparam logic [31:0] GAIN_ONE = 32'd1 << GAIN_FRAC_BITS;
    localparam gain_t GAIN_MAX = 16'h8000;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // exact floor division by small constants: multiply then shift by 31 + ceil(log2 k)
    localparam logic [31:0] COS_M [5] = '{
        32'(((64'd1 << 38) + 64'd89) / 64'd90),
        32'(((64'd1 << 37) + 64'd55) / 64'd56),
        32'(((64'd1 << 36) + 64'd29) / 64'd30),
        32'(((64'd1 << 35) + 64'd11) / 64'd12),
        32'(((64'd1 << 32) + 64'd1) / 64'd2)
    };
    localparam int COS_S [5] = '{38, 37, 36, 35, 32};

    localparam logic [31:0] SIN_M [4] = '{
        32'(((64'd1 << 38) + 64'd71) / 64'd72),
        32'(((64'd1 << 37) + 64'd41) / 64'd42),
        32'(((64'd1 << 36) + 64'd19) / 64'd20),
        32'(((64'd1 << 34) + 64'd5) / 64'd6)
    };
    localparam int SIN_S [4] = '{38, 37, 36, 34};

endpackage

// ----- rtl/radial_band_mask_unit.sv -----
// radial band mask: log cosine-taper gain per spectrum bin, fully pipelined
// One word enters per cycle while the output is not stalled; the pipeline is made of
// wrap, squaring, a 28-stage square root, a 17-stage divider, a 16-stage log2 squaring
// chain and a 10-stage sine/cosine polynomial, one register stage each. The whole pipeline
// moves whenever the output register is empty or taken, so s_tready follows m_tready
// directly. The configuration port is always ready; the user writes registers only while the
// block is idle (not enforced); derived copies (squares, band span) settle in the next cycle.
module radial_band_mask_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // column [9:0], row [19:10], zero [23:20]
    input  logic [0:0]          s_tuser,   // op [0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output rbm_pkg::gain_t      m_tdata,   // gain [15:0]
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  rbm_pkg::cfg_idx_t   cfg_index,
    input  rbm_pkg::dim_t       cfg_data
);
    import rbm_pkg::*;

    localparam int ST_CLS     = 3;
    localparam int ST_SQRT0   = 4;
    localparam int SQRT_STEPS = 28;
    localparam int ST_NUM     = ST_SQRT0 + SQRT_STEPS;
    localparam int DIV_STEPS  = 17;
    localparam int ST_LOGI    = ST_NUM + 1 + DIV_STEPS;
    localparam int LOG_STEPS  = 16;
    localparam int ST_FOLD    = ST_LOGI + 1 + LOG_STEPS;
    localparam int POLY_STEPS = 5;
    localparam int ST_OUT     = ST_FOLD + 3 + 2 * POLY_STEPS;
    localparam int NSTG       = ST_OUT + 1;

    logic en;

    // configuration
    dim_t width_reg, height_reg, inner_reg, outer_reg;
    logic [21:0] in2_reg, out2_reg;
    dim_t den_reg;
    logic den_nz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            inner_reg  <= INNER_RST;
            outer_reg  <= OUTER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_INNER:  inner_reg  <= cfg_data;
                REG_OUTER:  outer_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        in2_reg    <= {11'b0, inner_reg} * {11'b0, inner_reg};
        out2_reg   <= {11'b0, outer_reg} * {11'b0, outer_reg};
        den_reg    <= outer_reg - inner_reg;
        den_nz_reg <= (outer_reg != inner_reg);
    end

    // flow control and side information
    logic [NSTG-1:0] vld_reg;
    ctl_t ctl_reg [NSTG];
    band_t band_next;
    logic swap_next;

    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[0] <= '{op: s_tuser[0], band: BAND_TRANS, swap: 1'b0};
            for (int i = 1; i < NSTG; i++)
            begin
                if (i == ST_CLS)
                    ctl_reg[i] <= '{op: ctl_reg[i-1].op, band: band_next,
                                    swap: ctl_reg[i-1].swap};
                else if (i == ST_FOLD)
                    ctl_reg[i] <= '{op: ctl_reg[i-1].op, band: ctl_reg[i-1].band,
                                    swap: swap_next};
                else
                    ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // wrap, square, sum, band test
    logic signed [11:0] kx_reg, ky_reg, kx_next, ky_next;
    logic [21:0] sqx_reg, sqy_reg;
    logic [10:0] ax, ay;
    logic [22:0] d2_reg, cls_d2_reg;

    always_comb
    begin
        if (s_tdata[9:0] <= width_reg[10:1])
            kx_next = {2'b00, s_tdata[9:0]};
        else
            kx_next = {2'b00, s_tdata[9:0]} - {1'b0, width_reg};
        if (s_tdata[19:10] <= height_reg[10:1])
            ky_next = {2'b00, s_tdata[19:10]};
        else
            ky_next = {2'b00, s_tdata[19:10]} - {1'b0, height_reg};
        ax = kx_reg[11] ? 11'(-kx_reg) : kx_reg[10:0];
        ay = ky_reg[11] ? 11'(-ky_reg) : ky_reg[10:0];
        if (d2_reg > {1'b0, out2_reg})
            band_next = BAND_OUTSIDE;
        else if (d2_reg < {1'b0, in2_reg})
            band_next = BAND_INSIDE;
        else
            band_next = BAND_TRANS;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kx_reg     <= kx_next;
            ky_reg     <= ky_next;
            sqx_reg    <= {11'b0, ax} * {11'b0, ax};
            sqy_reg    <= {11'b0, ay} * {11'b0, ay};
            d2_reg     <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            cls_d2_reg <= d2_reg;
        end
    end

    // square root of d2 << 32, one result bit per stage
    logic [30:0] sq_rem_reg  [SQRT_STEPS];
    logic [27:0] sq_root_reg [SQRT_STEPS];
    logic [22:0] sq_d2_reg   [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        logic [30:0] rem_in, rem_sh, trial, rem_next;
        logic [27:0] root_in, root_next;
        logic [22:0] d2_in;
        logic [55:0] n_full;
        logic [1:0]  pair;

        if (j == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign d2_in   = cls_d2_reg;
        end
        else
        begin : g_rest
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
            assign d2_in   = sq_d2_reg[j-1];
        end

        assign n_full = {1'b0, d2_in, 32'b0};
        assign pair   = n_full[55-2*j -: 2];

        always_comb
        begin
            rem_sh = {rem_in[28:0], pair};
            trial  = {1'b0, root_in, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[26:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[26:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[j]  <= rem_next;
                sq_root_reg[j] <= root_next;
                sq_d2_reg[j]   <= d2_in;
            end
        end
    end

    // distance into the band
    logic [27:0] num_reg, num_next, base;

    always_comb
    begin
        base = {1'b0, inner_reg, 16'b0};
        if (sq_root_reg[SQRT_STEPS-1] > base)
            num_next = sq_root_reg[SQRT_STEPS-1] - base;
        else
            num_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            num_reg <= num_next;
    end

    // restoring divider by the band span, one quotient bit per stage
    logic [27:0] dv_rem_reg [DIV_STEPS];
    logic [16:0] dv_quo_reg [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        logic [27:0] rem_in, rem_next;
        logic [16:0] quo_in;
        logic [28:0] dsh;
        logic        take;

        if (i == 0)
        begin : g_first
            assign rem_in = num_reg;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = dv_rem_reg[i-1];
            assign quo_in = dv_quo_reg[i-1];
        end

        always_comb
        begin
            dsh      = {18'b0, den_reg} << (DIV_STEPS - 1 - i);
            take     = den_nz_reg && ({1'b0, rem_in} >= dsh);
            rem_next = take ? 28'({1'b0, rem_in} - dsh) : rem_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[i] <= rem_next;
                dv_quo_reg[i] <= {quo_in[15:0], take};
            end
        end
    end

    // log2(1 + t) by repeated squaring
    logic [30:0] lg_x0_reg;
    logic        lg_full0_reg;
    logic [30:0] lg_x_reg    [LOG_STEPS];
    logic [15:0] lg_u_reg    [LOG_STEPS];
    logic        lg_full_reg [LOG_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lg_full0_reg <= dv_quo_reg[DIV_STEPS-1][16];
            lg_x0_reg    <= {1'b1, dv_quo_reg[DIV_STEPS-1][15:0], 14'b0};
        end
    end

    for (genvar i = 0; i < LOG_STEPS; i++)
    begin : g_log
        logic [30:0] x_in, x_next;
        logic [15:0] u_in;
        logic        full_in;
        logic [61:0] sqr;
        logic [31:0] y;

        if (i == 0)
        begin : g_first
            assign x_in    = lg_x0_reg;
            assign u_in    = '0;
            assign full_in = lg_full0_reg;
        end
        else
        begin : g_rest
            assign x_in    = lg_x_reg[i-1];
            assign u_in    = lg_u_reg[i-1];
            assign full_in = lg_full_reg[i-1];
        end

        always_comb
        begin
            sqr    = {31'b0, x_in} * {31'b0, x_in};
            y      = sqr[61:30];
            x_next = y[31] ? y[31:1] : y[30:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lg_x_reg[i]    <= x_next;
                lg_u_reg[i]    <= {u_in[14:0], y[31]};
                lg_full_reg[i] <= full_in;
            end
        end
    end

    // fold to the first octant, angle and its square
    logic [16:0] uu;
    logic [15:0] v_reg, v_next;
    logic [46:0] ang_prod;
    logic [29:0] a_reg, ang_a_reg;
    logic [59:0] a_sq;
    logic [29:0] a2_reg;

    always_comb
    begin
        uu        = lg_full_reg[LOG_STEPS-1] ? 17'h10000 : {1'b0, lg_u_reg[LOG_STEPS-1]};
        swap_next = (uu > 17'd32768);
        v_next    = swap_next ? 16'(17'h10000 - uu) : uu[15:0];
        ang_prod  = {31'b0, v_reg} * {16'b0, HALF_PI_Q30};
        a_sq      = {30'b0, a_reg} * {30'b0, a_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg     <= v_next;
            a_reg     <= ang_prod[45:16];
            ang_a_reg <= a_reg;
            a2_reg    <= a_sq[59:30];
        end
    end

    // sine and cosine series, two stages per term
    logic [30:0] pa_s_reg  [POLY_STEPS];
    logic [30:0] pa_c_reg  [POLY_STEPS];
    logic [29:0] pa_a_reg  [POLY_STEPS];
    logic [29:0] pa_a2_reg [POLY_STEPS];
    logic [30:0] pb_s_reg  [POLY_STEPS];
    logic [30:0] pb_c_reg  [POLY_STEPS];
    logic [29:0] pb_a_reg  [POLY_STEPS];
    logic [29:0] pb_a2_reg [POLY_STEPS];

    for (genvar j = 0; j < POLY_STEPS; j++)
    begin : g_poly
        logic [30:0] acc_s_in, acc_c_in, s_next, c_next;
        logic [29:0] a_in, a2_in, mop;
        logic [60:0] prod_s, prod_c;
        logic [62:0] qc_full;

        if (j == 0)
        begin : g_first
            assign acc_s_in = Q30_ONE;
            assign acc_c_in = Q30_ONE;
            assign a_in     = ang_a_reg;
            assign a2_in    = a2_reg;
        end
        else
        begin : g_rest
            assign acc_s_in = pb_s_reg[j-1];
            assign acc_c_in = pb_c_reg[j-1];
            assign a_in     = pb_a_reg[j-1];
            assign a2_in    = pb_a2_reg[j-1];
        end

        // last sine term multiplies by the angle itself
        if (j == POLY_STEPS - 1)
        begin : g_sin_last
            assign mop    = a_in;
            assign s_next = pa_s_reg[j];
        end
        else
        begin : g_sin_term
            logic [62:0] qs_full;
            assign mop     = a2_in;
            assign qs_full = {32'b0, pa_s_reg[j]} * {31'b0, SIN_M[j]};
            assign s_next  = Q30_ONE - 31'(qs_full >> SIN_S[j]);
        end

        always_comb
        begin
            prod_s  = {31'b0, mop} * {30'b0, acc_s_in};
            prod_c  = {31'b0, a2_in} * {30'b0, acc_c_in};
            qc_full = {32'b0, pa_c_reg[j]} * {31'b0, COS_M[j]};
            c_next  = Q30_ONE - 31'(qc_full >> COS_S[j]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_s_reg[j]  <= prod_s[60:30];
                pa_c_reg[j]  <= prod_c[60:30];
                pa_a_reg[j]  <= a_in;
                pa_a2_reg[j] <= a2_in;
                pb_s_reg[j]  <= s_next;
                pb_c_reg[j]  <= c_next;
                pb_a_reg[j]  <= pa_a_reg[j];
                pb_a2_reg[j] <= pa_a2_reg[j];
            end
        end
    end

    // band override, mode select, rounding to the gain format
    ctl_t        oc;
    logic [30:0] lp, hp, val, sv, cv;
    logic [31:0] rnd, g;
    gain_t       gain_reg, gain_next;

    always_comb
    begin
        oc = ctl_reg[ST_OUT-1];
        sv = pb_s_reg[POLY_STEPS-1];
        cv = pb_c_reg[POLY_STEPS-1];
        case (oc.band)
            BAND_INSIDE:
            begin
                lp = Q30_ONE;
                hp = '0;
            end
            BAND_OUTSIDE:
            begin
                lp = '0;
                hp = Q30_ONE;
            end
            default:
            begin
                lp = oc.swap ? sv : cv;
                hp = oc.swap ? cv : sv;
            end
        endcase
        val = oc.op ? hp : lp;
        rnd = {1'b0, val} + GAIN_RND;
        g   = rnd >> GAIN_SH;
        if (g > GAIN_ONE)
            g = GAIN_ONE;
        gain_next = g[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            gain_reg <= gain_next;
    end

    assign m_tdata = gain_reg;

endmodule

// ----- rtl/rbm_checker.sv -----
// port checker for the radial band mask and its bind
`include "assert_macros.svh"

module rbm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input rbm_pkg::gain_t      m_tdata
);
    import rbm_pkg::*;

    // input side moves exactly when the output register can
    `RBM_ASSERT_ALWAYS(a_flow, clk, rst_n, s_tready == (!m_tvalid || m_tready))
    // gain never above unity
    `RBM_ASSERT_IMPLY(a_gain_range, clk, rst_n, m_tvalid, m_tdata <= GAIN_MAX)
    // stalled word holds
    `RBM_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind radial_band_mask_unit rbm_checker u_rbm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
